// File: rtl/nsv_pkg.sv
// Shared types, character codes and decode functions for the NMEA sentence validator.
// No dependencies; used by the parser, the result interface, the top level, the checker and the testbench.
package nsv_pkg;

	localparam logic [7:0] CH_START = 8'h24;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_LF    = 8'h0A;

	localparam logic [23:0] TYPE_GLL = 24'h474C4C;
	localparam logic [23:0] TYPE_GSA = 24'h475341;
	localparam logic [23:0] TYPE_GGA = 24'h474741;
	localparam logic [23:0] TYPE_RMC = 24'h524D43;

	localparam int unsigned LEN_W = 9;

	typedef enum logic [2:0] {
		KIND_OTHER = 3'd0,
		KIND_GLL   = 3'd1,
		KIND_GSA   = 3'd2,
		KIND_GGA   = 3'd3,
		KIND_RMC   = 3'd4
	} nsv_kind_t;

	typedef struct packed {
		nsv_kind_t        sentence_kind;
		logic             checksum_ok;
		logic             star_found;
		logic [7:0]       computed_sum;
		logic [7:0]       received_sum;
		logic [LEN_W-1:0] line_length;
	} nsv_result_t;

	// {digit ok, digit value}
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [7:0] d;
		begin
			d = 8'h00;
			if (c inside {[8'h30:8'h39]}) begin
				d = c - 8'h30;
				return {1'b1, d[3:0]};
			end
			if (c inside {[8'h41:8'h46]}) begin
				d = c - 8'h37;
				return {1'b1, d[3:0]};
			end
			if (c inside {[8'h61:8'h66]}) begin
				d = c - 8'h57;
				return {1'b1, d[3:0]};
			end
			return {1'b0, d[3:0]};
		end
	endfunction

	function automatic nsv_kind_t kind_decode(input logic [23:0] letters);
		begin
			case (letters)
				TYPE_GLL: return KIND_GLL;
				TYPE_GSA: return KIND_GSA;
				TYPE_GGA: return KIND_GGA;
				TYPE_RMC: return KIND_RMC;
				default:  return KIND_OTHER;
			endcase
		end
	endfunction

endpackage

// File: rtl/nsv_byte_if.sv
// Valid/ready channel carrying one received character per beat.
// Standalone; no package dependency.
interface nsv_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: rtl/nsv_result_if.sv
// Valid/ready channel carrying one sentence summary per beat.
// Field widths follow nsv_pkg.
interface nsv_result_if;
	logic                     valid;
	logic                     ready;
	logic [2:0]               sentence_kind;
	logic                     checksum_ok;
	logic                     star_found;
	logic [7:0]               computed_sum;
	logic [7:0]               received_sum;
	logic [nsv_pkg::LEN_W-1:0] line_length;

	modport source (output valid, output sentence_kind, output checksum_ok, output star_found,
		output computed_sum, output received_sum, output line_length, input ready);
	modport sink   (input valid, input sentence_kind, input checksum_ok, input star_found,
		input computed_sum, input received_sum, input line_length, output ready);
endinterface

// File: rtl/nsv_parser.sv
// Sentence state: running XOR, checksum digits, type letters and length counter.
// Depends on nsv_pkg; builds a result combinationally on the closing line feed.
module nsv_parser #(
	parameter int unsigned MAX_LENGTH = 511
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic [7:0]           rx_byte,
	output logic                 emit,
	output nsv_pkg::nsv_result_t res
);

	localparam int unsigned PW = $clog2(MAX_LENGTH + 1);
	localparam int unsigned WW = (PW > nsv_pkg::LEN_W) ? PW : nsv_pkg::LEN_W;

	logic          in_sentence_q;
	logic [7:0]    running_xor_q;
	logic          star_seen_q;
	logic [1:0]    hex_digit_count_q;
	logic [7:0]    hex_value_q;
	logic          hex_valid_q;
	logic [PW-1:0] byte_position_q;
	logic [23:0]   type_letters_q;

	logic          is_start;
	logic          is_lf;
	logic [PW-1:0] pos_inc;
	logic [WW-1:0] pos_wide;
	logic [4:0]    hex_d;
	logic          in_type;

	assign is_start = (rx_byte == nsv_pkg::CH_START);
	assign is_lf    = (rx_byte == nsv_pkg::CH_LF);
	assign pos_inc  = (byte_position_q < PW'(MAX_LENGTH)) ? byte_position_q + PW'(1)
		: byte_position_q;
	assign pos_wide = WW'(pos_inc);
	assign hex_d    = nsv_pkg::hex_decode(rx_byte);
	assign in_type  = (byte_position_q >= PW'(3)) && (byte_position_q <= PW'(5));

	assign emit = in_sentence_q && is_lf;

	always_comb begin
		res.sentence_kind   = nsv_pkg::kind_decode(type_letters_q);
		res.checksum_ok     = star_seen_q && hex_valid_q && (hex_digit_count_q == 2'd2)
			&& (running_xor_q == hex_value_q);
		res.star_found      = star_seen_q;
		res.computed_sum    = running_xor_q;
		res.received_sum    = hex_value_q;
		res.line_length     = (pos_wide > WW'(511)) ? {nsv_pkg::LEN_W{1'b1}}
			: pos_wide[nsv_pkg::LEN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_sentence_q     <= 1'b0;
			running_xor_q     <= 8'h00;
			star_seen_q       <= 1'b0;
			hex_digit_count_q <= 2'd0;
			hex_value_q       <= 8'h00;
			hex_valid_q       <= 1'b1;
			byte_position_q   <= '0;
			type_letters_q    <= 24'h000000;
		end else if (en) begin
			if (is_start) begin
				in_sentence_q     <= 1'b1;
				running_xor_q     <= 8'h00;
				star_seen_q       <= 1'b0;
				hex_digit_count_q <= 2'd0;
				hex_value_q       <= 8'h00;
				hex_valid_q       <= 1'b1;
				byte_position_q   <= PW'(1);
				type_letters_q    <= 24'h000000;
			end else if (in_sentence_q) begin
				byte_position_q <= pos_inc;
				if (is_lf) begin
					in_sentence_q <= 1'b0;
				end else begin
					if (in_type) begin
						type_letters_q <= {type_letters_q[15:0], rx_byte};
					end
					if (!star_seen_q) begin
						if (rx_byte == nsv_pkg::CH_STAR) begin
							star_seen_q <= 1'b1;
						end else begin
							running_xor_q <= running_xor_q ^ rx_byte;
						end
					end else if (hex_digit_count_q < 2'd2) begin
						hex_digit_count_q <= hex_digit_count_q + 2'd1;
						if (!hex_d[4]) begin
							hex_valid_q <= 1'b0;
						end else if (hex_valid_q) begin
							hex_value_q <= {hex_value_q[3:0], hex_d[3:0]};
						end
					end
				end
			end
		end
	end

endmodule

// File: rtl/nmea_sentence_validator_unit.sv
// NMEA sentence validator: input register, sentence parser, result register.
// A line feed beat passes the input register and then the result register before result.valid rises.
// Throughput: one byte per cycle; the input register and result register stall
// together only while a result waits untaken.
// Reset: arst_n clears both stage valids and all sentence state at once.
module nmea_sentence_validator_unit #(
	parameter int unsigned MAX_LENGTH = 511
) (
	input  logic                clk,
	input  logic                arst_n,
	nsv_byte_if.sink            rx,
	nsv_result_if.source        result
);

	logic                 rx_valid_s1;
	logic [7:0]           rx_byte_s1;
	logic                 advance;
	logic                 parse_en;
	logic                 emit;
	nsv_pkg::nsv_result_t res;
	logic                 res_valid_q;
	nsv_pkg::nsv_result_t res_q;

	assign advance  = !res_valid_q || result.ready;
	assign parse_en = rx_valid_s1 && advance;
	assign rx.ready = !rx_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			rx_valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			rx_byte_s1 <= rx.rx_byte;
		end
	end

	nsv_parser #(
		.MAX_LENGTH(MAX_LENGTH)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (parse_en),
		.rx_byte (rx_byte_s1),
		.emit    (emit),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= parse_en && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (parse_en && emit) begin
			res_q <= res;
		end
	end

	assign result.valid         = res_valid_q;
	assign result.sentence_kind = res_q.sentence_kind;
	assign result.checksum_ok   = res_q.checksum_ok;
	assign result.star_found    = res_q.star_found;
	assign result.computed_sum  = res_q.computed_sum;
	assign result.received_sum  = res_q.received_sum;
	assign result.line_length   = res_q.line_length;

endmodule

// File: rtl/nsv_checker.sv
// Port-level checks for nmea_sentence_validator_unit, attached by bind.
// Depends on nsv_pkg for the length width.
module nsv_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      res_valid,
	input logic                      res_ready,
	input logic [2:0]                sentence_kind,
	input logic                      checksum_ok,
	input logic                      star_found,
	input logic [7:0]                computed_sum,
	input logic [7:0]                received_sum,
	input logic [nsv_pkg::LEN_W-1:0] line_length
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(computed_sum)
		&& $stable(line_length) && $stable(checksum_ok))
		else $error("result beat changed while stalled");

	a_ok_match: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && checksum_ok |-> star_found && (computed_sum == received_sum))
		else $error("checksum_ok without matching sums");

	a_no_star: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !star_found |-> !checksum_ok && (received_sum == 8'h00))
		else $error("received sum without star");

	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> line_length >= nsv_pkg::LEN_W'(2))
		else $error("sentence shorter than start and line feed");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> sentence_kind <= 3'd4)
		else $error("unknown sentence kind");

endmodule

bind nmea_sentence_validator_unit nsv_checker u_nsv_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (result.valid),
	.res_ready     (result.ready),
	.sentence_kind (result.sentence_kind),
	.checksum_ok   (result.checksum_ok),
	.star_found    (result.star_found),
	.computed_sum  (result.computed_sum),
	.received_sum  (result.received_sum),
	.line_length   (result.line_length)
);

// File: tb/nsv_sentence_scoreboard_pkg.sv
// Sentence scoreboard for the NMEA sentence validator testbench.
// Tracks the open sentence byte by byte and queues the summary each line feed should produce.
// Depends on nsv_pkg for the character codes, type letters and result layout.
package nsv_sentence_scoreboard_pkg;

	localparam int unsigned LENGTH_CAP = 511;

	class sentence_scoreboard;
		bit                   in_sentence;
		logic [7:0]           xor_sum;
		bit                   star_seen;
		int unsigned          digit_count;
		logic [7:0]           digit_sum;
		bit                   digits_ok;
		int unsigned          position;
		logic [23:0]          letters;
		nsv_pkg::nsv_result_t summaries[$];
		int unsigned          errors;

		function new();
			in_sentence = 1'b0;
			xor_sum = 8'h00;
			star_seen = 1'b0;
			digit_count = 0;
			digit_sum = 8'h00;
			digits_ok = 1'b1;
			position = 0;
			letters = 24'h0;
			errors = 0;
		endfunction

		function int nibble_of(logic [7:0] c);
			if (c >= 8'h30 && c <= 8'h39) return c - 8'h30;
			if (c >= 8'h41 && c <= 8'h46) return c - 8'h41 + 10;
			if (c >= 8'h61 && c <= 8'h66) return c - 8'h61 + 10;
			return -1;
		endfunction

		function nsv_pkg::nsv_kind_t kind_of(logic [23:0] l);
			if (l == nsv_pkg::TYPE_GLL) return nsv_pkg::KIND_GLL;
			if (l == nsv_pkg::TYPE_GSA) return nsv_pkg::KIND_GSA;
			if (l == nsv_pkg::TYPE_GGA) return nsv_pkg::KIND_GGA;
			if (l == nsv_pkg::TYPE_RMC) return nsv_pkg::KIND_RMC;
			return nsv_pkg::KIND_OTHER;
		endfunction

		function int unsigned pending();
			return summaries.size();
		endfunction

		function void note_byte(logic [7:0] b);
			int unsigned at;
			int d;
			nsv_pkg::nsv_result_t s;
			if (b == nsv_pkg::CH_START) begin
				in_sentence = 1'b1;
				xor_sum = 8'h00;
				star_seen = 1'b0;
				digit_count = 0;
				digit_sum = 8'h00;
				digits_ok = 1'b1;
				position = 1;
				letters = 24'h0;
				return;
			end
			if (!in_sentence) return;
			at = position;
			if (position < LENGTH_CAP) position++;
			if (b == nsv_pkg::CH_LF) begin
				s.sentence_kind = kind_of(letters);
				s.checksum_ok = star_seen && digits_ok && digit_count == 2
					&& xor_sum == digit_sum;
				s.star_found = star_seen;
				s.computed_sum = xor_sum;
				s.received_sum = digit_sum;
				s.line_length = position[nsv_pkg::LEN_W-1:0];
				summaries.push_back(s);
				in_sentence = 1'b0;
				return;
			end
			if (at >= 3 && at <= 5) letters = {letters[15:0], b};
			if (!star_seen) begin
				if (b == nsv_pkg::CH_STAR) star_seen = 1'b1;
				else xor_sum = xor_sum ^ b;
			end else if (digit_count < 2) begin
				d = nibble_of(b);
				digit_count++;
				if (d < 0) digits_ok = 1'b0;
				else if (digits_ok) digit_sum = {digit_sum[3:0], d[3:0]};
			end
		endfunction

		function void field_mismatch(string name, logic [8:0] want, logic [8:0] got,
				longint unsigned stamp);
			if (want !== got) begin
				errors++;
				$display("[%0t ns] %s mismatch: expected %0d, actual %0d", stamp, name, want, got);
			end
		endfunction

		function void check_result(nsv_pkg::nsv_result_t got, longint unsigned stamp);
			nsv_pkg::nsv_result_t want;
			if (summaries.size() == 0) begin
				errors++;
				$display({"[%0t ns] unexpected beat: expected none, actual kind %0d ok %0b",
					" star %0b sum %02h/%02h length %0d"},
					stamp, got.sentence_kind, got.checksum_ok, got.star_found,
					got.computed_sum, got.received_sum, got.line_length);
				return;
			end
			want = summaries.pop_front();
			field_mismatch("sentence_kind", want.sentence_kind, got.sentence_kind, stamp);
			field_mismatch("checksum_ok", want.checksum_ok, got.checksum_ok, stamp);
			field_mismatch("star_found", want.star_found, got.star_found, stamp);
			field_mismatch("computed_sum", want.computed_sum, got.computed_sum, stamp);
			field_mismatch("received_sum", want.received_sum, got.received_sum, stamp);
			field_mismatch("line_length", want.line_length, got.line_length, stamp);
		endfunction
	endclass

endpackage

// File: tb/nmea_sentence_validator_unit_test.sv
// Top-level testbench for nmea_sentence_validator_unit: directed and random byte streams.
// Depends on nsv_pkg, the two channel interfaces and nsv_sentence_scoreboard_pkg.
module nmea_sentence_validator_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RANDOM_BYTES = 600;
	localparam int unsigned CALM_BYTES = 150;
	localparam int unsigned WATCHDOG_LIMIT = 2000;

	typedef enum int {
		FLAW_NONE,
		FLAW_BAD_SUM,
		FLAW_NO_STAR,
		FLAW_BAD_DIGIT,
		FLAW_SHORT_SUM,
		FLAW_RAW_BYTE,
		FLAW_RESTART,
		FLAW_LONG
	} flaw_t;

	logic clk;
	logic arst_n;
	bit idle_on = 1'b1;
	int unsigned bytes_sent = 0;
	nsv_sentence_scoreboard_pkg::sentence_scoreboard sb = new();

	nsv_byte_if rx();
	nsv_result_if result();

	nmea_sentence_validator_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx),
		.result(result)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic send_byte(input logic [7:0] b);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			rx.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		rx.valid <= 1'b1;
		rx.rx_byte <= b;
		@(posedge clk);
		while (!rx.ready) @(posedge clk);
		sb.note_byte(b);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i]);
	endtask

	task automatic send_nmea(input string body, input bit lower);
		logic [7:0] sum;
		sum = 8'h00;
		for (int i = 0; i < body.len(); i++) sum = sum ^ body[i];
		if (lower) send_text({"$", body, "*", $sformatf("%02x", sum), "\r\n"});
		else send_text({"$", body, "*", $sformatf("%02X", sum), "\r\n"});
	endtask

	function automatic logic [7:0] field_char();
		logic [7:0] c;
		c = 8'($urandom_range(32, 126));
		while (c == nsv_pkg::CH_START || c == nsv_pkg::CH_STAR) c = 8'($urandom_range(32, 126));
		return c;
	endfunction

	function automatic logic [7:0] hex_char(logic [3:0] n);
		if (n < 10) return 8'h30 + n;
		return 8'(($urandom_range(0, 1) ? 8'h61 : 8'h41) + n - 10);
	endfunction

	function automatic logic [7:0] upper_char();
		return 8'h41 + 8'($urandom_range(0, 25));
	endfunction

	task automatic send_random_sentence(input flaw_t flaw);
		logic [7:0] line[$];
		logic [7:0] sum;
		logic [7:0] sent;
		string types;
		string bad_digits;
		int unsigned count;
		int unsigned split;
		int unsigned digits;
		int unsigned pick;
		types = "GLLGSAGGARMC";
		bad_digits = "GZgz.,-/ ";
		line.push_back(nsv_pkg::CH_START);
		if ($urandom_range(0, 3) == 0) begin
			line.push_back(upper_char());
			line.push_back(upper_char());
		end else begin
			line.push_back("G");
			line.push_back("P");
		end
		pick = $urandom_range(0, 4);
		for (int i = 0; i < 3; i++) line.push_back(pick < 4 ? types[3 * pick + i] : upper_char());
		count = (flaw == FLAW_LONG) ? $urandom_range(495, 520) : $urandom_range(0, 20);
		split = $urandom_range(0, count);
		for (int i = 0; i < count; i++) begin
			if (i == split && flaw == FLAW_RAW_BYTE) begin
				line.push_back(8'($urandom_range(0, 255)));
			end else if (i == split && flaw == FLAW_RESTART) begin
				line.push_back(nsv_pkg::CH_START);
				foreach (types[k]) if (k < 3) line.push_back(k == 0 ? "G" : types[k + 5]);
			end else begin
				line.push_back(field_char());
			end
		end
		sum = 8'h00;
		foreach (line[i]) begin
			if (line[i] == nsv_pkg::CH_START) sum = 8'h00;
			else sum = sum ^ line[i];
		end
		if (flaw != FLAW_NO_STAR) begin
			line.push_back(nsv_pkg::CH_STAR);
			sent = (flaw == FLAW_BAD_SUM) ? sum ^ 8'($urandom_range(1, 255)) : sum;
			digits = (flaw == FLAW_SHORT_SUM) ? $urandom_range(0, 1) : 2;
			if (digits > 0) line.push_back(hex_char(sent[7:4]));
			if (digits > 1) line.push_back(hex_char(sent[3:0]));
			if (flaw == FLAW_BAD_DIGIT)
				line[line.size() - 1 - $urandom_range(0, 1)] =
					bad_digits[$urandom_range(0, bad_digits.len() - 1)];
		end
		if ($urandom_range(0, 1)) line.push_back(8'h0D);
		line.push_back(nsv_pkg::CH_LF);
		foreach (line[i]) send_byte(line[i]);
	endtask

	initial begin
		int hold;
		result.ready = 1'b0;
		hold = 0;
		forever begin
			@(posedge clk);
			if (result.valid && result.ready)
				sb.check_result('{nsv_pkg::nsv_kind_t'(result.sentence_kind),
					result.checksum_ok, result.star_found, result.computed_sum,
					result.received_sum, result.line_length}, $time);
			if (hold > 0) begin
				hold--;
				result.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				hold = $urandom_range(1, 6) - 1;
				result.ready <= 1'b0;
			end else begin
				result.ready <= 1'b1;
			end
		end
	end

	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((rx.valid && rx.ready) || (result.valid && result.ready)) quiet = 0;
			else quiet++;
		end
		$display("nmea_sentence_validator_unit regression: fail");
		$finish;
	end

	initial begin
		int unsigned start;
		int unsigned pick;
		arst_n = 1'b0;
		rx.valid = 1'b0;
		rx.rx_byte = 8'h00;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_byte(8'h00);
		send_byte(8'hFF);
		send_text("junk\n");
		send_nmea("GPGLL,4916.45,N,12311.12,W,225444,A", 1'b0);
		send_nmea("GNGSA,A,3,04,05,,09,12,,,24,,,,,2.5,1.3,2.1", 1'b1);
		send_nmea("GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,", 1'b0);
		send_nmea("GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W", 1'b1);
		send_nmea("GPVTG,054.7,T,034.4,M,005.5,N,010.2,K", 1'b0);
		send_text("$GPGLL,1,2*00\r\n");
		send_text("$GPGGA,1,2\r\n");
		send_text("$GPGSA,1*G1\r\n");
		send_text("$GPGSA,1*1z\r\n");
		send_text("$GPRMC,7*4\n");
		send_text("$GPRMC,7*\n");
		send_text("$GPGLL,x*5A**12\r\n");
		send_text("$GPGLL,abc");
		send_nmea("GPRMC,1", 1'b0);
		send_text("$\n");
		send_text("$GP\n");
		send_text("$GPGL\n");
		send_text("$GP*LL,1*00\n");
		send_nmea("GPABC,1", 1'b1);
		send_text("$GPGGA,");
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h80);
		send_text("*00\n");
		send_text("$GPGGA,");
		repeat (501) send_byte("A");
		send_text("*00\n");

		start = bytes_sent;
		while (bytes_sent - start < RANDOM_BYTES) begin
			idle_on = (bytes_sent - start) < RANDOM_BYTES - CALM_BYTES;
			pick = $urandom_range(0, 99);
			if (pick < 10) repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
			else if (pick < 72) send_random_sentence(FLAW_NONE);
			else if (pick < 99)
				send_random_sentence(flaw_t'($urandom_range(FLAW_BAD_SUM, FLAW_RESTART)));
			else send_random_sentence(FLAW_LONG);
		end
		rx.valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("nmea_sentence_validator_unit regression: pass");
		else
			$display("nmea_sentence_validator_unit regression: fail");
		$finish;
	end

endmodule
